[rtl/lcg48_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lcg48_pkg;

  // Generator state width and the recurrence constants.
  localparam int STATE_W = 48;
  localparam int MULT_W = 35;
  localparam logic [MULT_W-1:0] LCG_MULT = 35'h5_DEEC_E66D;
  localparam logic [STATE_W-1:0] LCG_INC = 48'hB;

  // The state is multiplied one chunk at a time.
  localparam int CHUNK_W = 16;
  localparam int N_CHUNKS = STATE_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(N_CHUNKS);
  localparam int PP_W = CHUNK_W + MULT_W;

  // A bounded draw uses the top 31 state bits.
  localparam int DRAW_W = 31;
  localparam int BIT_IDX_W = $clog2(DRAW_W);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam logic [COUNT_W-1:0] MAX_COUNT = 6'd32;

endpackage

`default_nettype wire

[rtl/lcg48_random_bounded.sv]
`timescale 1ns / 1ps
`default_nettype none

// 48-bit linear congruential random source with a bounded-integer mode.
//
// Input channel (in_valid / in_stall): one beat carries mode, bit_count and
// bound. Mode 0 returns the top bit_count bits of the advanced state; mode 1
// returns a value below bound (0 for bound 0), redrawing on a biased draw.
// Output channel (out_valid / out_stall): one beat of value per request.
// Seed port: a cycle with seed_we high loads the state with seed_wdata.
//
// Sequence: each draw runs the chunked state multiply, then a select step.
// Mode 0 and power-of-two bounds go on to the finish step, the latter through
// a scaling step. Other bounds add a restoring remainder over the draw bits
// and a check step; every rejected draw repeats the multiply, remainder and
// check. A new request is taken only after the result is loaded and the block
// is idle again, so requests do not overlap.
// in_stall is high from acceptance until the result reaches the output
// register. A result waiting under out_stall does not block the next request,
// but a finished request waits until the output register is free.
// Reset (synchronous, active high) clears the state to zero and drops
// out_valid. While out_valid and out_stall are both high, value holds.
module lcg48_random_bounded (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            seed_we,
  input  wire logic [lcg48_pkg::STATE_W-1:0]   seed_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            mode,
  input  wire logic [lcg48_pkg::COUNT_W-1:0]   bit_count,
  input  wire logic [lcg48_pkg::DRAW_W-1:0]    bound,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [lcg48_pkg::VALUE_W-1:0] value
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_POW  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam int SW = lcg48_pkg::STATE_W;
  localparam int DW = lcg48_pkg::DRAW_W;
  localparam int VW = lcg48_pkg::VALUE_W;

  logic [2:0]                          fsm;
  logic [SW-1:0]                       lcg_state;
  logic [SW-1:0]                       acc;
  logic [lcg48_pkg::CHUNK_IDX_W-1:0]   chunk_idx;
  logic                                mode_q;
  logic [lcg48_pkg::COUNT_W-1:0]       count_q;
  logic [DW-1:0]                       bound_q;
  logic [DW-1:0]                       draw;
  logic [DW-1:0]                       rem;
  logic [lcg48_pkg::BIT_IDX_W-1:0]     bit_idx;
  logic [2*DW-1:0]                     prod;
  logic [VW-1:0]                       result;

  logic                                accept;
  logic                                out_load;
  logic [lcg48_pkg::CHUNK_W-1:0]       chunk;
  logic [lcg48_pkg::PP_W-1:0]          pp_raw;
  logic [SW-1:0]                       pp;
  logic [SW-1:0]                       acc_next;
  logic [VW-1:0]                       top_bits;
  logic                                is_pow2;
  logic [DW:0]                         trial;
  logic [DW:0]                         trial_sub;
  logic [VW-1:0]                       chk;

  assign in_stall = (fsm != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // A finished result moves to the output register once it is free.
  assign out_load = (fsm == S_FIN) && (!out_valid || !out_stall);

  // One chunk of the state times the multiplier, placed at its weight.
  // Bits above the state width fall away, which is the modulo.
  assign chunk    = lcg_state[chunk_idx * lcg48_pkg::CHUNK_W +: lcg48_pkg::CHUNK_W];
  assign pp_raw   = lcg48_pkg::PP_W'(chunk) * lcg48_pkg::PP_W'(lcg48_pkg::LCG_MULT);
  assign pp       = SW'(pp_raw << (chunk_idx * lcg48_pkg::CHUNK_W));
  assign acc_next = acc + pp;

  // Top count_q bits of the state; a zero count gives zero.
  assign top_bits = (count_q == '0) ? '0 :
                    (lcg_state[SW-1 -: VW] >> (lcg48_pkg::MAX_COUNT - count_q));

  // Zero counts as a power of two here, as in the usual test.
  assign is_pow2 = ((bound_q & (~bound_q + 1'b1)) == bound_q);

  // One restoring step of the remainder.
  assign trial     = {rem, draw[bit_idx]};
  assign trial_sub = trial - {1'b0, bound_q};

  // Bias check, wrapped to 32 bits: negative means redraw.
  assign chk = VW'({1'b0, draw}) - VW'({1'b0, rem}) + VW'({1'b0, bound_q}) - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      out_valid <= 1'b0;
      lcg_state <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (fsm)
        S_IDLE: begin
          if (accept) begin
            mode_q    <= mode;
            count_q   <= (bit_count > lcg48_pkg::MAX_COUNT) ? lcg48_pkg::MAX_COUNT
                                                             : bit_count;
            bound_q   <= bound;
            acc       <= lcg48_pkg::LCG_INC;
            chunk_idx <= '0;
            fsm       <= S_MUL;
          end
        end
        S_MUL: begin
          acc       <= acc_next;
          chunk_idx <= chunk_idx + 1'b1;
          if (chunk_idx == lcg48_pkg::CHUNK_IDX_W'(lcg48_pkg::N_CHUNKS - 1)) begin
            lcg_state <= acc_next;
            fsm       <= S_SEL;
          end
        end
        S_SEL: begin
          draw <= lcg_state[SW-1 -: DW];
          prod <= bound_q * lcg_state[SW-1 -: DW];
          rem  <= '0;
          bit_idx <= lcg48_pkg::BIT_IDX_W'(DW - 1);
          if (!mode_q) begin
            result <= top_bits;
            fsm    <= S_FIN;
          end else if (is_pow2) begin
            fsm <= S_POW;
          end else begin
            fsm <= S_DIV;
          end
        end
        S_POW: begin
          result <= VW'(prod[2*DW-1:DW]);
          fsm    <= S_FIN;
        end
        S_DIV: begin
          rem     <= trial_sub[DW] ? trial[DW-1:0] : trial_sub[DW-1:0];
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == '0) begin
            fsm <= S_CHK;
          end
        end
        S_CHK: begin
          if (chk[VW-1]) begin
            acc       <= lcg48_pkg::LCG_INC;
            chunk_idx <= '0;
            fsm       <= S_MUL;
          end else begin
            result <= VW'(rem);
            fsm    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            value <= result;
            fsm   <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
      if (seed_we) begin
        lcg_state <= seed_wdata;
      end
    end
  end

  // The running remainder always stays below the bound.
  a_rem_below_bound: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_DIV || fsm == S_CHK) |-> (rem < bound_q))
    else $error("remainder reached the bound");

  // A power-of-two result lies below a nonzero bound.
  a_pow_below_bound: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_POW && bound_q != '0) |-> (prod[2*DW-1:DW] < bound_q))
    else $error("scaled draw not below bound");

  // An accepted request starts its multiply at the lowest chunk.
  a_start_mul: assert property (@(posedge clk) disable iff (rst)
    accept |=> (fsm == S_MUL && chunk_idx == '0))
    else $error("request did not start the multiply");

  // The chunk counter never runs past the last chunk.
  a_chunk_range: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_MUL) |-> (chunk_idx < lcg48_pkg::CHUNK_IDX_W'(lcg48_pkg::N_CHUNKS)))
    else $error("chunk index out of range");

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(value)))
    else $error("waiting result was overwritten");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_BOUNDED = 1'b1;

  // Constants of the recurrence, at the full state width.
  localparam logic [47:0] GEN_MULT = 48'h0005_DEEC_E66D;
  localparam logic [47:0] GEN_INC = 48'h0000_0000_000B;

  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 200;
  localparam int CALM_ITEMS = 50;
  localparam int DRAIN_CYCLES = 60;

  typedef enum logic {ROW_ITEM, ROW_SEED} row_kind_t;

  // One row of the directed table. A row is either a request or a seed load.
  // Where 'typed' is set, 'want' is the known answer, and it is checked in
  // place of the predictor's value.
  typedef struct packed {
    row_kind_t   kind;
    logic        m;
    logic [5:0]  bc;
    logic [30:0] bn;
    logic [47:0] seed;
    logic        typed;
    logic [31:0] want;
  } row_t;

  localparam int N_ROWS = 25;
  localparam row_t DIRECTED [0:N_ROWS-1] = '{
    // From the zero state, the first draw lands on 0xB. Its top 32 bits are 0.
    '{ROW_ITEM, MODE_RAW,     6'd32, 31'd0,           48'd0, 1'b1, 32'd0},
    // A zero bit count gives 0. The all-ones bound is ignored in raw mode.
    '{ROW_ITEM, MODE_RAW,     6'd0,  31'h7FFF_FFFF,   48'd0, 1'b1, 32'd0},
    // A zero bound counts as a power of two and gives 0. Bit count is ignored.
    '{ROW_ITEM, MODE_BOUNDED, 6'd63, 31'd0,           48'd0, 1'b1, 32'd0},
    // A bound of one can only give 0.
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'd1,           48'd0, 1'b1, 32'd0},
    '{ROW_ITEM, MODE_RAW,     6'd1,  31'd0,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_RAW,     6'd31, 31'd0,           48'd0, 1'b0, 32'd0},
    // Counts above 32 saturate.
    '{ROW_ITEM, MODE_RAW,     6'd33, 31'd0,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_RAW,     6'd63, 31'h2AAA_AAAA,   48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd5,  31'd2,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'h4000_0000,   48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'd3,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'd7,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'h7FFF_FFFF,   48'd0, 1'b0, 32'd0},
    // Just above 2^30, about half of all draws fail the bias check.
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'h4000_0001,   48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'h4000_0003,   48'd0, 1'b0, 32'd0},
    '{ROW_SEED, MODE_RAW,     6'd0,  31'd0,  48'hFFFF_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_RAW,     6'd32, 31'd0,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'd1000,        48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'h5555_5555,   48'd0, 1'b0, 32'd0},
    '{ROW_SEED, MODE_RAW,     6'd0,  31'd0,           48'd1, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_RAW,     6'd16, 31'd0,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'd6,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_BOUNDED, 6'd0,  31'h4000_0000,   48'd0, 1'b0, 32'd0},
    // After the state is reloaded with zero, the first draw is known again.
    '{ROW_SEED, MODE_RAW,     6'd0,  31'd0,           48'd0, 1'b0, 32'd0},
    '{ROW_ITEM, MODE_RAW,     6'd32, 31'd0,           48'd0, 1'b1, 32'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seed_we = 1'b0;
  logic [lcg48_pkg::STATE_W-1:0] seed_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [lcg48_pkg::COUNT_W-1:0] bit_count = '0;
  logic [lcg48_pkg::DRAW_W-1:0] bound = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [lcg48_pkg::VALUE_W-1:0] value;

  lcg48_random_bounded dut (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .bit_count  (bit_count),
    .bound      (bound),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // This is the predictor's copy of the generator state. The model of a seed
  // load updates it too.
  logic [47:0] gen_state = '0;
  logic [31:0] expected_values [$];

  int errors = 0;
  int items_sent = 0;
  int values_checked = 0;
  int redraws = 0;
  int seeds_loaded = 0;

  // These flags steer the receiver: 'calm' turns all idling off, and
  // 'long_hold' asks for one long stall.
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  // This function advances the state once and returns its top k bits, for k
  // from 0 to 32. Zero bits read as 0.
  function automatic logic [31:0] advance_generator(input int unsigned k);
    gen_state = gen_state * GEN_MULT + GEN_INC;
    if (k == 0) return 32'd0;
    return 32'(gen_state >> (48 - k));
  endfunction

  function automatic logic [31:0] predict_value(input logic m, input logic [5:0] bc,
                                               input logic [30:0] bn);
    logic [31:0] n;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] check;
    logic [63:0] scaled;
    int unsigned k;
    n = {1'b0, bn};
    if (m == MODE_RAW) begin
      k = (bc > 6'd32) ? 32 : int'(bc);
      return advance_generator(k);
    end
    // The power-of-two path scales 31 bits by the bound. Zero takes it too.
    if ((n & (~n + 32'd1)) == n) begin
      b = advance_generator(31);
      scaled = 64'(n) * 64'(b);
      return 32'(scaled >> 31);
    end
    // Otherwise the draw is reduced modulo the bound. A draw that lands in the
    // biased tail wraps the check negative, and then another draw is taken.
    do begin
      b = advance_generator(31);
      r = b % n;
      check = b - r + n - 32'd1;
      if (check[31]) redraws++;
    end while (check[31]);
    return r;
  endfunction

  // This task offers one request beat and returns at the edge that accepts it.
  // The valid line is left high, so that back-to-back beats need no gap.
  task automatic offer_request(input logic m, input logic [5:0] bc, input logic [30:0] bn,
                               input logic typed, input logic [31:0] want);
    logic [31:0] predicted;
    mode <= m;
    bit_count <= bc;
    bound <= bn;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_value(m, bc, bn);
    expected_values.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic hold_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // A seed is loaded only once every outstanding result has been taken.
  // Every request gives exactly one result, so an empty queue means the
  // block is idle.
  task automatic load_seed(input logic [47:0] s);
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    seed_we <= 1'b1;
    seed_wdata <= s;
    @(posedge clk);
    seed_we <= 1'b0;
    gen_state = s;
    seeds_loaded++;
  endtask

  // The spread of bounds reaches every path: powers of two (zero among them),
  // small bounds, bounds that reject often, and bounds near the 31-bit maximum.
  function automatic logic [30:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return 31'(32'd1 << $urandom_range(0, 31));
      1: return 31'($urandom_range(1, 100));
      2: return 31'h4000_0000 + 31'($urandom_range(1, 32'h0FFF_FFFF));
      3: return 31'h7FFF_FFFF - 31'($urandom_range(0, 1000));
      default: return 31'($urandom);
    endcase
  endfunction

  // The receiver stalls in random bursts. When asked, it holds off once for
  // a long stretch, while the sender goes on offering requests.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Result checker. Values are sampled at the edge that takes them.
  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected value beat %h", value));
      end else begin
        want = expected_values.pop_front();
        values_checked++;
        if (value !== want)
          report_mismatch($sformatf("value %h, expected %h", value, want));
      end
    end
  end

  initial begin : main_sequence
    int i;
    int p;
    int j;
    logic m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed table starts from the reset state, with a seed of zero.
    for (i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_SEED)
        load_seed(DIRECTED[i].seed);
      else
        offer_request(DIRECTED[i].m, DIRECTED[i].bc, DIRECTED[i].bn,
                      DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases. Each begins from a fresh seed, and the last runs flat out.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      load_seed(48'({$urandom, $urandom}));
      calm = (p == RANDOM_PHASES - 1);
      if (p == 2) long_hold = 1'b1;
      for (j = 0; j < (calm ? CALM_ITEMS : PHASE_ITEMS); j++) begin
        if (!calm && !long_hold && $urandom_range(0, 99) < 20)
          hold_sender($urandom_range(1, 10));
        m = ($urandom_range(0, 9) < 4) ? MODE_RAW : MODE_BOUNDED;
        offer_request(m, 6'($urandom_range(0, 63)), pick_bound(), 1'b0, 32'd0);
      end
    end
    in_valid <= 1'b0;

    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d seed loads, with %0d rejection redraws.",
             items_sent, seeds_loaded, redraws);
    $display("Compared %0d result beats; %0d mismatches.", values_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The watchdog allows several times the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/lcg48_pkg.sv
rtl/lcg48_random_bounded.sv
verif/testbench.sv
